// ===== sv/msr_pkg.sv =====
// msr_pkg: item types, function, action and status codes of the multicast
// sequence receiver. No dependencies; every other file imports it.
package msr_pkg;

    // Function codes of an input item
    localparam logic [1:0] FUNC_START   = 2'd0;
    localparam logic [1:0] FUNC_PACKET  = 2'd1;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

    // Action codes of a result item
    localparam logic [2:0] ACT_IGNORE  = 3'd0;
    localparam logic [2:0] ACT_DELIVER = 3'd1;
    localparam logic [2:0] ACT_REPLY   = 3'd2;
    localparam logic [2:0] ACT_LOSS    = 3'd3;
    localparam logic [2:0] ACT_RELEASE = 3'd4;

    // Ending status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ABORT   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam logic [31:0] SEQ_ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [15:0] SEG_BYTES_RST = 16'd544;

    typedef struct packed {
        logic [1:0]  func;
        logic [30:0] read_length;
        logic        sync_after;
        logic [31:0] packet_seq;
        logic [31:0] barrier_word;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] deliver_bytes;
        logic [31:0] reply_seq;
        logic        finished;
        logic [1:0]  status;
    } t_out_item;

    // Handshake between the input stage and the core
    typedef struct packed {
        logic valid;    // input stage holds an item
        logic advance;  // downstream can take a result this cycle
    } t_stage_ctl;

endpackage

// ===== sv/msr_in_stage.sv =====
// msr_in_stage: input register of the receiver, holds one item.
// Depends on msr_pkg.
module msr_in_stage
    import msr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_item   i_item,
    input  logic       i_advance,
    output t_stage_ctl o_ctl,
    output t_in_item   o_item
);

    logic     r_valid;
    t_in_item r_item;

    // Free slot, or the held item moves on this cycle
    assign o_ready = !r_valid || i_advance;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_ctl.valid   = r_valid;
    assign o_ctl.advance = i_advance;
    assign o_item        = r_item;

endmodule

// ===== sv/msr_core.sv =====
// msr_core: read state of the receiver and the per-item decision logic.
// Depends on msr_pkg.
module msr_core
    import msr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_stage_ctl  i_ctl,
    input  t_in_item    i_item,
    input  logic [15:0] i_segment_bytes,
    output t_out_item   o_result
);

    logic [31:0] r_expected_seq, n_expected_seq;
    logic [30:0] r_bytes_left,   n_bytes_left;
    logic        r_sync_pending, n_sync_pending;
    logic        r_read_active,  n_read_active;

    logic        fire;
    logic [31:0] exp_eff;
    logic [31:0] next_seq;
    logic [30:0] seg_ext;
    logic [15:0] take;
    logic [30:0] left_after;
    logic        start_active;

    assign fire = i_ctl.valid && i_ctl.advance;

    // Number wrap: packet 1 against all ones restarts the count
    assign exp_eff  = (i_item.packet_seq == 32'd1 && r_expected_seq == SEQ_ALL_ONES)
                      ? 32'd0 : r_expected_seq;
    assign next_seq = exp_eff + 32'd1;

    // Segment size clipped by what is left
    assign seg_ext    = {15'd0, i_segment_bytes};
    assign take       = (r_bytes_left < seg_ext) ? r_bytes_left[15:0] : i_segment_bytes;
    assign left_after = r_bytes_left - {15'd0, take};

    assign start_active = (i_item.read_length != 31'd0) || i_item.sync_after;

    // Next state and result
    always_comb begin
        n_expected_seq = r_expected_seq;
        n_bytes_left   = r_bytes_left;
        n_sync_pending = r_sync_pending;
        n_read_active  = r_read_active;
        o_result       = '0;
        o_result.action = ACT_IGNORE;
        o_result.status = ST_OK;

        if (i_item.func == FUNC_START) begin
            n_bytes_left      = i_item.read_length;
            n_sync_pending    = i_item.sync_after;
            n_read_active     = start_active;
            o_result.finished = !start_active;
        end else if (r_read_active) begin
            case (i_item.func)
                FUNC_TIMEOUT: begin
                    n_read_active     = 1'b0;
                    o_result.finished = 1'b1;
                    if (r_bytes_left == 31'd0) begin
                        n_expected_seq = r_expected_seq + 32'd1;
                    end else begin
                        o_result.status = ST_TIMEOUT;
                    end
                end
                FUNC_PACKET: begin
                    n_expected_seq = exp_eff;
                    if (i_item.packet_seq == 32'd0) begin
                        // Control packet: sync request or abort
                        if (i_item.barrier_word != 32'd0) begin
                            o_result.action    = ACT_REPLY;
                            o_result.reply_seq = exp_eff;
                        end else begin
                            n_read_active     = 1'b0;
                            o_result.finished = 1'b1;
                            o_result.status   = ST_ABORT;
                        end
                    end else if (i_item.packet_seq == next_seq) begin
                        n_expected_seq = next_seq;
                        if (r_bytes_left == 31'd0) begin
                            n_read_active     = 1'b0;
                            o_result.action   = ACT_RELEASE;
                            o_result.finished = 1'b1;
                        end else begin
                            n_bytes_left           = left_after;
                            o_result.action        = ACT_DELIVER;
                            o_result.deliver_bytes = take;
                            if (left_after == 31'd0 && !r_sync_pending) begin
                                n_read_active     = 1'b0;
                                o_result.finished = 1'b1;
                            end
                        end
                    end else if (i_item.packet_seq > next_seq) begin
                        o_result.action = ACT_LOSS;
                    end
                end
                default: begin
                    // unused code: ignored
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_seq <= '0;
            r_bytes_left   <= '0;
            r_sync_pending <= 1'b0;
            r_read_active  <= 1'b0;
        end else if (fire) begin
            r_expected_seq <= n_expected_seq;
            r_bytes_left   <= n_bytes_left;
            r_sync_pending <= n_sync_pending;
            r_read_active  <= n_read_active;
        end
    end

endmodule

// ===== sv/mcast_sequence_receiver.sv =====
// mcast_sequence_receiver: top level of the multicast sequence receiver.
// Depends on msr_pkg, msr_in_stage and msr_core.
//
// Takes one item per cycle while the output is not stalled (start read,
// packet header, timeout) and returns exactly one result item for each:
// the item is registered in the input stage, then decided against the read
// state, and the result is registered. The rate of one item per cycle is
// set by the core updating its read state for every item (sequence compare,
// segment clipping and byte count subtract). The segment size register resets
// to 544 and is written through the config channel, which is always ready;
// write it only while no item is in flight.
module mcast_sequence_receiver
    import msr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_segment_bytes;
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic        advance;
    t_stage_ctl  stage_ctl;
    t_in_item    stage_item;
    t_out_item   result;

    // Output register frees up or is empty
    assign advance = !r_out_valid || i_out_ready;

    msr_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (i_in_item),
        .i_advance (advance),
        .o_ctl     (stage_ctl),
        .o_item    (stage_item)
    );

    msr_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (stage_ctl),
        .i_item          (stage_item),
        .i_segment_bytes (r_segment_bytes),
        .o_result        (result)
    );

    // Segment size register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segment_bytes <= SEG_BYTES_RST;
        end else if (i_cfg_valid) begin
            r_segment_bytes <= i_cfg_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= stage_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && stage_ctl.valid) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== sv/msr_checker.sv =====
// msr_checker: port-level assertions for mcast_sequence_receiver, with the
// bind that attaches them. Depends on msr_pkg.
module msr_checker
    import msr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    // An item taken with the output empty passes the input stage and the result register and shows up
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |-> ##2 o_out_valid)
        else $error("accepted item produced no result");

    // Status is only reported when the read finishes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.finished |-> o_out_item.status == ST_OK)
        else $error("status without finish");

    // Byte count and reply number only with their own actions
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_item.action == ACT_DELIVER || o_out_item.deliver_bytes == 16'd0) &&
            (o_out_item.action == ACT_REPLY || o_out_item.reply_seq == 32'd0))
        else $error("payload field set for wrong action");

endmodule

bind mcast_sequence_receiver msr_checker u_msr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ===== dv/msr_result_checker.sv =====
// msr_result_checker: watches the item, result and config channels of the
// multicast sequence receiver, predicts each result and compares it.
// Depends on msr_pkg only.
module msr_result_checker
    import msr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_item,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_item,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output int          o_pending,
    output int          o_fail_count
);

    // Shadow of the receiver's read state and segment size
    logic [15:0] seg_size     = SEG_BYTES_RST;
    logic [31:0] seq_last     = '0;
    logic [30:0] left_bytes   = '0;
    logic        wait_release = 1'b0;
    logic        armed        = 1'b0;

    t_out_item   predicted_out[$];
    int          fail_total = 0;

    // Decide one item against the shadow state and update it
    function automatic t_out_item decide_item(input t_in_item it);
        t_out_item   r;
        logic [31:0] nxt;
        logic [30:0] take;
        r = '0;
        r.action = ACT_IGNORE;
        r.status = ST_OK;
        if (it.func == FUNC_START) begin
            left_bytes   = it.read_length;
            wait_release = it.sync_after;
            armed        = (it.read_length != '0) || it.sync_after;
            r.finished   = !armed;
            return r;
        end
        // idle, or the unused function code
        if (!armed || (it.func != FUNC_PACKET && it.func != FUNC_TIMEOUT)) begin
            return r;
        end
        if (it.func == FUNC_TIMEOUT) begin
            armed      = 1'b0;
            r.finished = 1'b1;
            if (left_bytes == '0) begin
                seq_last = seq_last + 32'd1;
            end else begin
                r.status = ST_TIMEOUT;
            end
            return r;
        end
        // packet header; number 1 after all ones restarts the count
        if (it.packet_seq == 32'd1 && seq_last == SEQ_ALL_ONES) begin
            seq_last = '0;
        end
        if (it.packet_seq == '0) begin
            if (it.barrier_word != '0) begin
                r.action    = ACT_REPLY;
                r.reply_seq = seq_last;
            end else begin
                armed      = 1'b0;
                r.finished = 1'b1;
                r.status   = ST_ABORT;
            end
            return r;
        end
        nxt = seq_last + 32'd1;
        if (it.packet_seq == nxt) begin
            seq_last = nxt;
            if (left_bytes == '0) begin
                armed      = 1'b0;
                r.action   = ACT_RELEASE;
                r.finished = 1'b1;
                return r;
            end
            take = (left_bytes < {15'd0, seg_size}) ? left_bytes : {15'd0, seg_size};
            left_bytes      = left_bytes - take;
            r.action        = ACT_DELIVER;
            r.deliver_bytes = take[15:0];
            if (left_bytes == '0 && !wait_release) begin
                armed      = 1'b0;
                r.finished = 1'b1;
            end
        end else if (it.packet_seq > nxt) begin
            r.action = ACT_LOSS;
        end
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Results are matched before new items are queued: a result never
    // belongs to the item taken on the same edge
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            seg_size     = SEG_BYTES_RST;
            seq_last     = '0;
            left_bytes   = '0;
            wait_release = 1'b0;
            armed        = 1'b0;
            predicted_out.delete();
            o_pending    <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (predicted_out.size() == 0) begin
                    note_failure($sformatf(
                        "unexpected result: action %0d bytes %0d reply %0d fin %0b st %0d",
                        i_out_item.action, i_out_item.deliver_bytes,
                        i_out_item.reply_seq, i_out_item.finished, i_out_item.status));
                end else begin
                    want = predicted_out.pop_front();
                    if (i_out_item !== want) begin
                        note_failure($sformatf(
                            {"result mismatch: expected action %0d bytes %0d reply %0d ",
                             "fin %0b st %0d, got action %0d bytes %0d reply %0d ",
                             "fin %0b st %0d"},
                            want.action, want.deliver_bytes, want.reply_seq,
                            want.finished, want.status,
                            i_out_item.action, i_out_item.deliver_bytes,
                            i_out_item.reply_seq, i_out_item.finished,
                            i_out_item.status));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                seg_size = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                predicted_out.push_back(decide_item(i_in_item));
            end
            o_pending <= predicted_out.size();
        end
        o_fail_count <= fail_total;
    end

endmodule

// ===== dv/tb.sv =====
// tb: stimulus and verdict for the multicast sequence receiver: directed
// items, then reads of random shape over several segment sizes.
// Depends on msr_pkg, mcast_sequence_receiver and msr_result_checker.
module tb;
    import msr_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         ITEM_TARGET = 1450;
    localparam int         PHASES      = 9;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_item    in_item   = '0;
    logic        in_ready;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data  = '0;
    logic        cfg_ready;
    int          pending;
    int          fail_count;

    logic [31:0] seq_sent = '0;   // last in-order number sent
    logic [15:0] cur_seg  = SEG_BYTES_RST;
    int          counted  = 0;
    bit          no_gap   = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    mcast_sequence_receiver DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    msr_result_checker CHK (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Mostly short gaps, a few long ones; none in quiet phases
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gap || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Unused fields carry random bits
    function automatic t_in_item rand_item(input logic [1:0] f);
        t_in_item it;
        it.func         = f;
        it.read_length  = 31'($urandom);
        it.sync_after   = 1'($urandom);
        it.packet_seq   = $urandom;
        it.barrier_word = $urandom;
        return it;
    endfunction

    function automatic t_in_item start_item(input logic [30:0] len, input logic sync);
        t_in_item it;
        it             = rand_item(FUNC_START);
        it.read_length = len;
        it.sync_after  = sync;
        return it;
    endfunction

    function automatic t_in_item pkt_item(input logic [31:0] seq);
        t_in_item it;
        it            = rand_item(FUNC_PACKET);
        it.packet_seq = seq;
        return it;
    endfunction

    function automatic t_in_item ctl_item(input logic [31:0] bar);
        t_in_item it;
        it              = rand_item(FUNC_PACKET);
        it.packet_seq   = '0;
        it.barrier_word = bar;
        return it;
    endfunction

    // Offer one item and hold it until taken
    task automatic push_item(input t_in_item it, input bit counts);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (counts) begin
            counted++;
        end
    endtask

    // Drain: every predicted result has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_seg(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_seg = v;
    endtask

    // Out-of-order traffic inside an armed read; may end the read
    task automatic send_noise(input bit allow_end, output bit ended);
        int r;
        ended = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 7 && seq_sent != '0) begin
            push_item(pkt_item($urandom_range(1, seq_sent)), 1'b0);
        end else if (r < 14) begin
            push_item(pkt_item(seq_sent + 32'd2 + $urandom_range(0, 1000)), 1'b1);
        end else if (r < 17) begin
            push_item(pkt_item($urandom | 32'h8000_0000), 1'b1);
        end else if (r < 21) begin
            push_item(ctl_item($urandom | 32'd1), 1'b1);
        end else if (r < 23) begin
            push_item(rand_item(FUNC_UNUSED), 1'b0);
        end else if (r < 25) begin
            if (!allow_end) begin
                push_item(ctl_item($urandom | 32'd1), 1'b1);
            end else begin
                if ($urandom_range(0, 1) == 0) begin
                    push_item(rand_item(FUNC_TIMEOUT), 1'b1);
                end else begin
                    push_item(ctl_item('0), 1'b1);
                end
                ended = 1'b1;
            end
        end
    endtask

    // One read: start, in-order data with noise, then release or an early end
    task automatic run_read();
        logic [30:0] len;
        bit          sync;
        bit          ended;
        bit          left_armed;
        longint      npk;
        int          sent, k, r, lim;
        r          = $urandom_range(0, 99);
        lim        = 8;
        left_armed = 1'b0;
        sync       = 1'($urandom);
        if (r < 5) begin
            len  = '0;
            sync = 1'b0;
        end else if (r < 12) begin
            len  = '0;
            sync = 1'b1;
        end else if (r < 18) begin
            len = 31'($urandom) | 31'h4000_0000;
            lim = $urandom_range(0, 4);
        end else begin
            len = 31'($urandom_range(1, (cur_seg == 0 ? 100 : cur_seg) * 6));
        end
        if (len == '0) begin
            npk = 0;
        end else if (cur_seg == 0) begin
            npk = lim + 1;
        end else begin
            npk = (longint'(len) + cur_seg - 1) / cur_seg;
        end
        sent = (npk > lim) ? lim : int'(npk);
        push_item(start_item(len, sync), 1'b1);
        ended = (len == '0) && !sync;
        for (k = 0; k < sent && !ended; k++) begin
            send_noise(1'b1, ended);
            if (!ended) begin
                push_item(pkt_item(seq_sent + 32'd1), 1'b1);
                seq_sent++;
            end
        end
        if (!ended) begin
            if (npk > sent) begin
                // data still owed: time out, abort, or leave it for the next start
                r = $urandom_range(0, 2);
                if (r == 0) begin
                    push_item(rand_item(FUNC_TIMEOUT), 1'b1);
                end else if (r == 1) begin
                    push_item(ctl_item('0), 1'b1);
                end else begin
                    left_armed = 1'b1;
                end
            end else if (sync) begin
                // only the release is owed; a timeout also ends it ok
                send_noise(1'b0, ended);
                if ($urandom_range(0, 4) == 0) begin
                    push_item(rand_item(FUNC_TIMEOUT), 1'b1);
                end else begin
                    push_item(pkt_item(seq_sent + 32'd1), 1'b1);
                end
                seq_sent++;
            end
        end
        // stray traffic while idle
        if (!left_armed && $urandom_range(0, 4) == 0) begin
            r = $urandom_range(0, 2);
            push_item(rand_item(r == 0 ? FUNC_PACKET : (r == 1 ? FUNC_TIMEOUT : FUNC_UNUSED)),
                      1'b0);
        end
    endtask

    // Result sink: bursts of ready with random stalls
    initial begin : sink
        int run, hold;
        @(posedge clk);
        forever begin
            run = $urandom_range(1, 24);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            hold = pick_gap();
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    initial begin : stim
        logic [15:0] seg_val;
        int          p;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle: packet, timeout and unused code are ignored
        push_item(pkt_item(32'd1), 1'b1);
        push_item(rand_item(FUNC_TIMEOUT), 1'b1);
        push_item(rand_item(FUNC_UNUSED), 1'b1);
        // empty start finishes at once
        push_item(start_item('0, 1'b0), 1'b1);
        // two segments at the reset size, with duplicate, loss and sync reply
        push_item(start_item(31'd1000, 1'b1), 1'b1);
        push_item(pkt_item(32'd1), 1'b1);
        seq_sent++;
        push_item(pkt_item(32'd1), 1'b1);
        push_item(pkt_item(32'd3), 1'b1);
        push_item(pkt_item(SEQ_ALL_ONES), 1'b1);
        push_item(ctl_item(32'hFFFF_FFFF), 1'b1);
        push_item(pkt_item(32'd2), 1'b1);
        seq_sent++;
        push_item(ctl_item(32'd1), 1'b1);
        push_item(pkt_item(32'd3), 1'b1);
        seq_sent++;
        // largest length, then starts that replace a running read
        push_item(start_item(31'h7FFF_FFFF, 1'b0), 1'b1);
        push_item(rand_item(FUNC_UNUSED), 1'b1);
        push_item(start_item(31'd5000, 1'b1), 1'b1);
        push_item(start_item(31'd3, 1'b0), 1'b1);
        push_item(pkt_item(32'd4), 1'b1);
        seq_sent++;
        // timeout with only the release owed ends ok and bumps the number
        push_item(start_item('0, 1'b1), 1'b1);
        push_item(rand_item(FUNC_TIMEOUT), 1'b1);
        seq_sent++;
        // server abort
        push_item(start_item(31'd10, 1'b0), 1'b1);
        push_item(ctl_item('0), 1'b1);
        // timeout with data owed
        push_item(start_item(31'd2000, 1'b1), 1'b1);
        push_item(rand_item(FUNC_TIMEOUT), 1'b1);

        // random reads over several segment sizes, zero and the extremes first
        for (p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: begin
                    seg_val = 16'd0;
                end
                1: begin
                    seg_val = 16'd1;
                end
                2: begin
                    seg_val = 16'hFFFF;
                end
                3: begin
                    seg_val = 16'($urandom);
                end
                default: begin
                    seg_val = 16'($urandom_range(1, 1500));
                end
            endcase
            write_seg(seg_val);
            no_gap = (p % 3 == 1);
            while (counted < (ITEM_TARGET * (p + 1)) / PHASES) run_read();
        end

        settle();
        repeat (4) @(posedge clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
